>>> hdl/apt_pkg.sv
// Shared widths, codes and types for the affine point transform.
`timescale 1ns / 1ps
package apt_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int COEF_WIDTH      = 16;
  localparam int FRAC_BITS       = COEF_WIDTH - 2;
  localparam int ROW_WIDTH       = 3 * COEF_WIDTH;
  localparam int VEC_WIDTH       = COORD_WIDTH + 1;
  localparam int PROD_WIDTH      = VEC_WIDTH + COEF_WIDTH;
  localparam int SUM_WIDTH       = PROD_WIDTH + 2;
  localparam int SHIFTED_WIDTH   = SUM_WIDTH - FRAC_BITS;
  localparam int ACC_WIDTH       = SHIFTED_WIDTH + 1;
  localparam int CFG_DATA_WIDTH  = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW0    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW1    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW2    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Z = 3'd5;

  localparam logic [1:0] OP_POINT         = 2'd0;
  localparam logic [1:0] OP_DIRECTION     = 2'd1;
  localparam logic [1:0] OP_INV_DIRECTION = 2'd2;
  localparam logic [1:0] OP_INV_POINT     = 2'd3;

  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [VEC_WIDTH-1:0]   vec_t;

  // rot[r][c]: row r, column c of the rotation
  typedef struct packed {
    coef_t  [2:0][2:0] rot;
    coord_t [2:0]      shift;
  } cfg_t;

  // coef[i][j]: weight of input component j in output component i
  typedef struct packed {
    logic              valid;
    logic              add_shift;
    vec_t   [2:0]      vec;
    coef_t  [2:0][2:0] coef;
    coord_t [2:0]      shift;
  } operand_t;

endpackage

>>> hdl/apt_cfg_regs.sv
// Configuration register file: rotation rows and translation.
`timescale 1ns / 1ps
module apt_cfg_regs
  import apt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                       cfg
);

  logic [2:0][ROW_WIDTH-1:0]   rows;
  logic [2:0][COORD_WIDTH-1:0] shifts;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        rows[r]   <= ROW_WIDTH'(1) << (FRAC_BITS + r * COEF_WIDTH);
        shifts[r] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0:    rows[0]   <= cfg_data[ROW_WIDTH-1:0];
        REG_ROW1:    rows[1]   <= cfg_data[ROW_WIDTH-1:0];
        REG_ROW2:    rows[2]   <= cfg_data[ROW_WIDTH-1:0];
        REG_SHIFT_X: shifts[0] <= cfg_data[COORD_WIDTH-1:0];
        REG_SHIFT_Y: shifts[1] <= cfg_data[COORD_WIDTH-1:0];
        REG_SHIFT_Z: shifts[2] <= cfg_data[COORD_WIDTH-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cfg.rot[r][c] = rows[r][c*COEF_WIDTH +: COEF_WIDTH];
      end
      cfg.shift[r] = shifts[r];
    end
  end

endmodule

>>> hdl/apt_operand_sel.sv
// First stage: pre-subtract translation and pick plain or transposed weights.
`timescale 1ns / 1ps
module apt_operand_sel
  import apt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  logic [1:0] operation,
  input  coord_t   in_x,
  input  coord_t   in_y,
  input  coord_t   in_z,
  input  cfg_t     cfg,
  output operand_t opnd
);

  operand_t opnd_next;
  coord_t [2:0] vin;
  logic transpose;
  logic subtract;

  always_comb begin
    vin = {in_z, in_y, in_x};
    case (operation)
      OP_POINT:         begin transpose = 1'b0; subtract = 1'b0; end
      OP_DIRECTION:     begin transpose = 1'b0; subtract = 1'b0; end
      OP_INV_DIRECTION: begin transpose = 1'b1; subtract = 1'b0; end
      OP_INV_POINT:     begin transpose = 1'b1; subtract = 1'b1; end
      default:          begin transpose = 1'b0; subtract = 1'b0; end
    endcase
    opnd_next.valid     = take;
    opnd_next.add_shift = (operation == OP_POINT);
    opnd_next.shift     = cfg.shift;
    for (int j = 0; j < 3; j++) begin
      // one extra bit keeps the difference from wrapping
      if (subtract)
        opnd_next.vec[j] = VEC_WIDTH'($signed(vin[j])) - VEC_WIDTH'($signed(cfg.shift[j]));
      else
        opnd_next.vec[j] = VEC_WIDTH'($signed(vin[j]));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        opnd_next.coef[i][j] = transpose ? cfg.rot[j][i] : cfg.rot[i][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opnd.valid <= 1'b0;
    end else begin
      opnd.valid <= opnd_next.valid;
    end
    opnd.add_shift <= opnd_next.add_shift;
    opnd.vec       <= opnd_next.vec;
    opnd.coef      <= opnd_next.coef;
    opnd.shift     <= opnd_next.shift;
  end

endmodule

>>> hdl/apt_dot_pipe.sv
// Multiply, sum, rescale, translate and saturate: three register stages.
`timescale 1ns / 1ps
module apt_dot_pipe
  import apt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  operand_t opnd,
  output logic     done,
  output coord_t   out_x,
  output coord_t   out_y,
  output coord_t   out_z
);

  typedef logic signed [PROD_WIDTH-1:0]    prod_t;
  typedef logic signed [SUM_WIDTH-1:0]     sum_t;
  typedef logic signed [SHIFTED_WIDTH-1:0] shifted_t;
  typedef logic signed [ACC_WIDTH-1:0]     acc_t;

  function automatic coord_t saturate(input acc_t v);
    logic [ACC_WIDTH-COORD_WIDTH:0] top;
    begin
      top = v[ACC_WIDTH-1:COORD_WIDTH-1];
      if ((&top) || !(|top))
        saturate = v[COORD_WIDTH-1:0];
      else if (v[ACC_WIDTH-1])
        saturate = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      else
        saturate = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  // products stage
  logic              prod_valid;
  logic              prod_add_shift;
  coord_t [2:0]      prod_shift;
  prod_t [2:0][2:0]  prod;

  // accumulate stage
  logic              acc_valid;
  acc_t [2:0]        acc;
  acc_t [2:0]        acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= opnd.valid;
    end
    prod_add_shift <= opnd.add_shift;
    prod_shift     <= opnd.shift;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= PROD_WIDTH'($signed(opnd.vec[j]) * $signed(opnd.coef[i][j]));
      end
    end
  end

  always_comb begin
    sum_t     sum;
    shifted_t scaled;
    for (int i = 0; i < 3; i++) begin
      sum = SUM_WIDTH'($signed(prod[i][0])) + SUM_WIDTH'($signed(prod[i][1]))
          + SUM_WIDTH'($signed(prod[i][2]));
      // dropping the fraction bits floors toward minus infinity
      scaled = sum[SUM_WIDTH-1:FRAC_BITS];
      acc_next[i] = ACC_WIDTH'($signed(scaled))
                  + (prod_add_shift ? ACC_WIDTH'($signed(prod_shift[i])) : acc_t'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      acc_valid <= prod_valid;
      done      <= acc_valid;
    end
    acc   <= acc_next;
    out_x <= saturate(acc[0]);
    out_y <= saturate(acc[1]);
    out_z <= saturate(acc[2]);
  end

endmodule

>>> hdl/affine_point_transform.sv
// Top level of the affine point transform: 3x4 fixed-point vertex transform.
`timescale 1ns / 1ps
//
//  channel   ports                                  transfer
//  --------  -------------------------------------  ---------------------------------
//  command   start, busy, operation, in_x/y/z       edge with start high, busy low
//  result    done, out_x, out_y, out_z              edge ending the cycle done is high
//  config    cfg_we, cfg_index, cfg_data            edge with cfg_we high
//
//  One vector enters per clock while busy is low; after the command transfer
//  edge it passes the four register stages (operand select, nine products,
//  sum and translate, saturate), and done is registered with the result in the last.
//  busy is high only during reset and the cycle after it; then it stays low.
//  The result side cannot stall, so every stage advances each clock.
//  Write configuration only while no vector is in flight.
module affine_point_transform
  import apt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 operation,
  input  coord_t                     in_x,
  input  coord_t                     in_y,
  input  coord_t                     in_z,
  output logic                       done,
  output coord_t                     out_x,
  output coord_t                     out_y,
  output coord_t                     out_z,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t     cfg;
  operand_t opnd;
  logic     take;

  // Hold off commands while reset is applied and in the cycle after it.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign take = start && !busy;

  apt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage 1: apply v - T for the inverse point and pick the weight matrix.
  apt_operand_sel u_operand_sel (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .operation (operation),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .cfg       (cfg),
    .opnd      (opnd)
  );

  // Stages 2 to 4: products, rescaled sums with translation, saturation.
  apt_dot_pipe u_dot_pipe (
    .clk   (clk),
    .rst   (rst),
    .opnd  (opnd),
    .done  (done),
    .out_x (out_x),
    .out_y (out_y),
    .out_z (out_z)
  );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the affine point transform.
`timescale 1ns / 1ps
//
// Drive a directed table first, then eight random phases. Each phase
// reprograms the matrix and translation while the pipe is empty, then streams
// vectors. Every command transfer pushes its expected vector into a FIFO. The
// result monitor pops that FIFO on each done strobe and compares per field.
// Random sender gaps land on every pipe stage. The last phase streams back to
// back.
module tb_top;
  import apt_pkg::*;

  localparam coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN = 32'sh8000_0000;
  // Indexes past the register list: writes there must be dropped.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int DRAIN_LIMIT     = 64;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  // One line of the directed table: a register write or a vector command.
  typedef struct {
    bit                         is_write;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;
    logic [1:0]                 op;
    vec3_t                      vin;
    bit                         use_preset;
    vec3_t                      preset;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [1:0]                 operation;
  coord_t                     in_x;
  coord_t                     in_y;
  coord_t                     in_z;
  logic                       done;
  coord_t                     out_x;
  coord_t                     out_y;
  coord_t                     out_z;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  // Shadow copy of the programmed matrix: rot_m[row][col], plus translation.
  coef_t  rot_m [3][3];
  coord_t shift_v [3];

  vec3_t     result_q [$];
  stim_row_t plan [$];
  int        fail_count = 0;

  always #5 clk = ~clk;

  affine_point_transform dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Track a register write in the shadow matrix. Drop spare indexes and the
  // bits above each register's width.
  function automatic void track_write(logic [CFG_INDEX_WIDTH-1:0] index,
                                      logic [CFG_DATA_WIDTH-1:0] data);
    case (index)
      REG_ROW0, REG_ROW1, REG_ROW2: begin
        for (int c = 0; c < 3; c++) rot_m[index][c] = data[c*COEF_WIDTH +: COEF_WIDTH];
      end
      REG_SHIFT_X: shift_v[0] = data[COORD_WIDTH-1:0];
      REG_SHIFT_Y: shift_v[1] = data[COORD_WIDTH-1:0];
      REG_SHIFT_Z: shift_v[2] = data[COORD_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  // Exact dot products in 64 bits, floor shift, optional translate, clamp.
  function automatic vec3_t transform_vector(logic [1:0] op, vec3_t vin);
    longint v [3];
    longint acc;
    longint w;
    coord_t res [3];
    v[0] = vin.x;
    v[1] = vin.y;
    v[2] = vin.z;
    // Inverse point: subtract first; 64 bits hold the 33-bit difference.
    if (op == OP_INV_POINT) begin
      for (int i = 0; i < 3; i++) v[i] -= shift_v[i];
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        // Forward ops use row i; inverse ops walk column i (plain transpose).
        w = (op == OP_POINT || op == OP_DIRECTION) ? rot_m[i][j] : rot_m[j][i];
        acc += v[j] * w;
      end
      acc = acc >>> FRAC_BITS;
      if (op == OP_POINT) acc += shift_v[i];
      if (acc > longint'(C_MAX)) res[i] = C_MAX;
      else if (acc < longint'(C_MIN)) res[i] = C_MIN;
      else res[i] = coord_t'(acc);
    end
    return '{x: res[0], y: res[1], z: res[2]};
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'hC000;
      4: return coef_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'(int'($urandom_range(0, 262143)) - 131072);
      3: return coord_t'(-int'($urandom_range(0, 3)));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic stim_row_t write_row(logic [CFG_INDEX_WIDTH-1:0] index,
                                          logic [CFG_DATA_WIDTH-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.index    = index;
    r.data     = data;
    return r;
  endfunction

  // Vector row; with use_preset set, the given outputs are checked instead of
  // the predictor's.
  function automatic stim_row_t vector_row(logic [1:0] op, coord_t x, coord_t y, coord_t z,
                                           bit use_preset = 1'b0,
                                           coord_t wx = '0, coord_t wy = '0,
                                           coord_t wz = '0);
    stim_row_t r;
    r = '{default: '0};
    r.op         = op;
    r.vin        = '{x: x, y: y, z: z};
    r.use_preset = use_preset;
    r.preset     = '{x: wx, y: wy, z: wz};
    return r;
  endfunction

  // Drive one register write at the falling edge; the next drive decides cfg_we.
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index,
                           logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    track_write(index, data);
    @(negedge clk);
  endtask

  // Hold the command until it transfers, then queue its expected vector.
  // Leave start high so back-to-back commands need no extra edge.
  task automatic send_vector(logic [1:0] op, vec3_t vin, bit use_preset, vec3_t preset);
    start     <= 1'b1;
    cfg_we    <= 1'b0;
    operation <= op;
    in_x      <= vin.x;
    in_y      <= vin.y;
    in_z      <= vin.z;
    do @(posedge clk); while (busy !== 1'b0);
    result_q.push_back(use_preset ? preset : transform_vector(op, vin));
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending and wait for the pipe to empty; flag anything that never shows.
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (result_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      fail_count++;
      result_q.delete();
    end
  endtask

  // Sample on the rising edge that ends the done cycle and match the oldest
  // expectation field by field.
  always @(posedge clk) begin : result_check
    vec3_t want;
    if (!rst && done === 1'b1) begin
      if (result_q.size() == 0) begin
        $error("unexpected result %0d %0d %0d", out_x, out_y, out_z);
        fail_count++;
      end else begin
        want = result_q.pop_front();
        if (out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, out_x);
          fail_count++;
        end
        if (out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, out_y);
          fail_count++;
        end
        if (out_z !== want.z) begin
          $error("out_z: expected %0d, got %0d", want.z, out_z);
          fail_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run (every item after the longest sender gap).
  initial begin
    #(2_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    bit        prev_write;
    coef_t     cf [3];
    logic [1:0] op;
    vec3_t     vin;
    bit        quiet;

    rst       = 1'b1;
    start     = 1'b0;
    operation = OP_POINT;
    in_x      = '0;
    in_y      = '0;
    in_z      = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) rot_m[r][c] = (r == c) ? coef_t'(1 << FRAC_BITS) : '0;
      shift_v[r] = '0;
    end

    // Reset state is identity with no translation, so every op passes v through.
    plan.push_back(vector_row(OP_POINT, 0, 0, 0, 1, 0, 0, 0));
    plan.push_back(vector_row(OP_POINT, C_MAX, C_MIN, 32'sh0001_0000, 1,
                              C_MAX, C_MIN, 32'sh0001_0000));
    plan.push_back(vector_row(OP_DIRECTION, C_MIN, C_MAX, -1, 1, C_MIN, C_MAX, -1));
    plan.push_back(vector_row(OP_INV_DIRECTION, 32'sh1234_5678, -5, 7, 1,
                              32'sh1234_5678, -5, 7));
    plan.push_back(vector_row(OP_INV_POINT, C_MAX, C_MIN, 32'sh0001_0000, 1,
                              C_MAX, C_MIN, 32'sh0001_0000));
    plan.push_back(vector_row(OP_POINT, -1, -1, -1, 1, -1, -1, -1));

    // Extreme coefficients: row 0 all max, row 1 all min, row 2 zero.
    // Garbage above bit 31 of the translation registers must be dropped.
    plan.push_back(write_row(REG_ROW0, {3{16'h7FFF}}));
    plan.push_back(write_row(REG_ROW1, {3{16'h8000}}));
    plan.push_back(write_row(REG_ROW2, '0));
    plan.push_back(write_row(REG_SHIFT_X, 48'hFFFF_7FFF_FFFF));
    plan.push_back(write_row(REG_SHIFT_Y, 48'h5A5A_8000_0000));
    plan.push_back(write_row(REG_SHIFT_Z, 48'hABCD_0001_2345));
    // Saturation both ways; z is the translation alone.
    plan.push_back(vector_row(OP_POINT, C_MAX, C_MAX, C_MAX, 1,
                              C_MAX, C_MIN, 32'sh0001_2345));
    plan.push_back(vector_row(OP_POINT, C_MIN, C_MIN, C_MIN, 1,
                              C_MIN, C_MAX, 32'sh0001_2345));
    plan.push_back(vector_row(OP_DIRECTION, C_MAX, C_MAX, C_MAX, 1, C_MAX, C_MIN, 0));
    plan.push_back(vector_row(OP_INV_DIRECTION, 1, 2, 3));
    // v - T spans 33 bits here and must not wrap.
    plan.push_back(vector_row(OP_INV_POINT, C_MIN, C_MAX, 0));
    plan.push_back(vector_row(OP_INV_POINT, C_MAX, C_MIN, C_MIN));

    // Small and mixed coefficients for floor rounding; spare indexes dropped.
    plan.push_back(write_row(REG_ROW0, {3{16'h0001}}));
    plan.push_back(write_row(REG_ROW1, {16'hC000, 16'h2D41, 16'h2D41}));
    plan.push_back(write_row(REG_ROW2, {16'h4000, 16'hC000, 16'h0000}));
    plan.push_back(write_row(REG_SHIFT_X, 48'h0000_FFFF_FFFF));
    plan.push_back(write_row(REG_SHIFT_Y, 48'h0000_0001_0000));
    plan.push_back(write_row(REG_SHIFT_Z, '0));
    plan.push_back(write_row(REG_SPARE_LO, '1));
    plan.push_back(write_row(REG_SPARE_HI, 48'h1234_5678_9ABC));
    plan.push_back(vector_row(OP_POINT, -1, -1, -1));
    plan.push_back(vector_row(OP_DIRECTION, 1, 1, 1));
    plan.push_back(vector_row(OP_INV_DIRECTION, 32'sh0001_0000, -32'sh0001_0000,
                              32'sh7FFF_0000));
    plan.push_back(vector_row(OP_INV_POINT, C_MIN, C_MAX, C_MIN));
    plan.push_back(vector_row(OP_POINT, C_MAX, 0, C_MIN));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table; drain the pipe before the first write of each group.
    prev_write = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!prev_write) drain_results();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_vector(plan[i].op, plan[i].vin, plan[i].use_preset, plan[i].preset);
      end
      prev_write = plan[i].is_write;
    end

    // Random phases: phase 1 pins every coefficient and translation at the top,
    // phase 2 at the bottom; the rest mix extremes, small and random values.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      for (int idx = REG_ROW0; idx <= REG_SHIFT_Z; idx++) begin
        if (idx <= REG_ROW2) begin
          for (int c = 0; c < 3; c++) begin
            case (phase)
              1: cf[c] = 16'h7FFF;
              2: cf[c] = 16'h8000;
              default: cf[c] = rand_coef();
            endcase
          end
          write_reg(CFG_INDEX_WIDTH'(idx), {cf[2], cf[1], cf[0]});
        end else begin
          write_reg(CFG_INDEX_WIDTH'(idx),
                    {16'($urandom), (phase == 1) ? C_MAX : (phase == 2) ? C_MIN : rand_coord()});
        end
      end
      if ($urandom_range(0, 1)) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  {16'($urandom), 32'($urandom)});
      end

      // Keep the final phase gap-free so the pipe runs full for a long stretch.
      quiet = (phase == RAND_PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op  = 2'($urandom_range(0, 3));
        vin = '{x: rand_coord(), y: rand_coord(), z: rand_coord()};
        send_vector(op, vin, 1'b0, '0);
        if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 16));
      end
    end

    // Let the pipe empty, then keep watching for stray strobes before the verdict.
    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/apt_pkg.sv
hdl/apt_cfg_regs.sv
hdl/apt_operand_sel.sv
hdl/apt_dot_pipe.sv
hdl/affine_point_transform.sv
bench/tb_top.sv
